### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

### rtl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Types and constants of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mct_pkg;

    localparam int COORD_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int DELTA_W    = 9;

    localparam logic [COORD_W-1:0] DEFAULT_WIDTH  = COORD_W'(1920);
    localparam logic [COORD_W-1:0] DEFAULT_HEIGHT = COORD_W'(1080);

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic EVT_MOTION      = 1'b0;
    localparam logic EVT_BUTTON      = 1'b1;
    localparam logic BUTTON_ID_LEFT  = 1'b0;
    localparam logic BUTTON_ID_RIGHT = 1'b1;

    localparam int STAT_LEFT  = 0;
    localparam int STAT_RIGHT = 1;
    localparam int STAT_XSIGN = 4;
    localparam int STAT_YSIGN = 5;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] dx_byte;
        logic [7:0] dy_byte;
    } packet_t;

    typedef struct packed {
        logic               event_kind;
        logic [COORD_W-1:0] cursor_col;
        logic [COORD_W-1:0] cursor_row;
        logic               button_id;
        logic               button_down;
        logic               last_of_run;
    } event_t;

endpackage

`default_nettype wire

### rtl/ps2_mouse_cursor_tracker_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_top
// A packet goes into the input register, then into the result register, which
// emits its results in turn; the next packet can wait in the input register,
// and the result register empties as that packet moves in.
// Reset: cursor at (960, 540), buttons released, screen 1920 x 1080.
// Decodes 3-byte PS/2 mouse packets, tracks a clamped cursor and the two
// button states, and emits motion and button-change results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ps2_mouse_cursor_tracker_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  pkt_valid,
    output      logic                                  pkt_stall,
    input  wire ps2mct_pkg::packet_t                   pkt,
    output      logic                                  evt_valid,
    input  wire logic                                  evt_stall,
    output      ps2mct_pkg::event_t                    evt,
    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic [ps2mct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ps2mct_pkg::COORD_W-1:0]        cfg_data
);
    import ps2mct_pkg::*;

    localparam int SUM_W = COORD_W + 2;

    logic                 width_zero;
    logic [COORD_W-1:0]   width_reg;
    logic [COORD_W-1:0]   height_reg;
    logic [COORD_W-1:0]   cursor_x_reg;
    logic [COORD_W-1:0]   cursor_y_reg;
    logic [COORD_W-1:0]   cursor_x_next;
    logic [COORD_W-1:0]   cursor_y_next;
    logic                 left_was_reg;
    logic                 right_was_reg;

    logic                 in_valid_reg;
    packet_t              in_reg;

    logic                 motion_pend_reg;
    logic                 left_pend_reg;
    logic                 right_pend_reg;
    logic                 left_dn_reg;
    logic                 right_dn_reg;
    logic [COORD_W-1:0]   col_reg;
    logic [COORD_W-1:0]   row_reg;

    logic                 pkt_xfer;
    logic                 evt_xfer;
    logic                 run_done;
    logic                 load;
    logic                 cfg_wr;

    logic [COORD_W-1:0]   w_eff;
    logic [COORD_W-1:0]   h_eff;
    logic [COORD_W-1:0]   w_new;
    logic [COORD_W-1:0]   h_new;
    logic [DELTA_W-1:0]   dx9;
    logic [DELTA_W-1:0]   dy9;
    logic signed [SUM_W-1:0] x_sum;
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] x_hi;
    logic signed [SUM_W-1:0] y_hi;
    logic [COORD_W-1:0]   x_clamped;
    logic [COORD_W-1:0]   y_clamped;
    logic                 left_now;
    logic                 right_now;

    assign width_zero = (width_reg == '0);
    assign w_eff      = width_zero ? DEFAULT_WIDTH : width_reg;
    assign h_eff      = (height_reg == '0) ? DEFAULT_HEIGHT : height_reg;

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign evt_valid = motion_pend_reg || left_pend_reg || right_pend_reg;
    assign evt_xfer  = evt_valid && !evt_stall;
    assign run_done  = evt_xfer && evt.last_of_run;
    assign load      = in_valid_reg && (!evt_valid || run_done);
    assign pkt_stall = in_valid_reg && !load;
    assign pkt_xfer  = pkt_valid && !pkt_stall;

    // motion and clamp
    always_comb
    begin
        dx9   = {in_reg.status_byte[STAT_XSIGN], in_reg.dx_byte};
        dy9   = {in_reg.status_byte[STAT_YSIGN], in_reg.dy_byte};
        x_sum = $signed({2'b00, cursor_x_reg})
                + $signed({{(SUM_W-DELTA_W){dx9[DELTA_W-1]}}, dx9});
        y_sum = $signed({2'b00, cursor_y_reg})
                - $signed({{(SUM_W-DELTA_W){dy9[DELTA_W-1]}}, dy9});
        x_hi  = $signed({2'b00, w_eff - COORD_W'(1)});
        y_hi  = $signed({2'b00, h_eff - COORD_W'(1)});
        if (x_sum < 0)
        begin
            x_clamped = '0;
        end
        else if (x_sum > x_hi)
        begin
            x_clamped = x_hi[COORD_W-1:0];
        end
        else
        begin
            x_clamped = x_sum[COORD_W-1:0];
        end
        if (y_sum < 0)
        begin
            y_clamped = '0;
        end
        else if (y_sum > y_hi)
        begin
            y_clamped = y_hi[COORD_W-1:0];
        end
        else
        begin
            y_clamped = y_sum[COORD_W-1:0];
        end
        left_now  = in_reg.status_byte[STAT_LEFT];
        right_now = in_reg.status_byte[STAT_RIGHT];
    end

    // next cursor: re-centre on a screen size write, else apply the clamped motion on load
    always_comb
    begin
        w_new         = w_eff;
        h_new         = h_eff;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cfg_wr && (cfg_index == REG_SCREEN_WIDTH || cfg_index == REG_SCREEN_HEIGHT))
        begin
            if (cfg_index == REG_SCREEN_WIDTH)
            begin
                w_new = (cfg_data == '0) ? DEFAULT_WIDTH : cfg_data;
            end
            else
            begin
                h_new = (cfg_data == '0) ? DEFAULT_HEIGHT : cfg_data;
            end
            cursor_x_next = w_new >> 1;
            cursor_y_next = h_new >> 1;
        end
        else if (load)
        begin
            cursor_x_next = x_clamped;
            cursor_y_next = y_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DEFAULT_WIDTH;
            height_reg    <= DEFAULT_HEIGHT;
            cursor_x_reg  <= DEFAULT_WIDTH >> 1;
            cursor_y_reg  <= DEFAULT_HEIGHT >> 1;
            left_was_reg  <= 1'b0;
            right_was_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (load)
            begin
                left_was_reg  <= left_now;
                right_was_reg <= right_now;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pkt_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_xfer)
        begin
            in_reg <= pkt;
        end
    end

    // result register: pending results of one packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_pend_reg <= 1'b0;
            left_pend_reg   <= 1'b0;
            right_pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            motion_pend_reg <= 1'b1;
            left_pend_reg   <= (left_now != left_was_reg);
            right_pend_reg  <= (right_now != right_was_reg);
        end
        else if (evt_xfer)
        begin
            if (motion_pend_reg)
            begin
                motion_pend_reg <= 1'b0;
            end
            else if (left_pend_reg)
            begin
                left_pend_reg <= 1'b0;
            end
            else
            begin
                right_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg      <= x_clamped;
            row_reg      <= y_clamped;
            left_dn_reg  <= left_now;
            right_dn_reg <= right_now;
        end
    end

    always_comb
    begin
        evt.cursor_col = col_reg;
        evt.cursor_row = row_reg;
        if (motion_pend_reg)
        begin
            evt.event_kind  = EVT_MOTION;
            evt.button_id   = BUTTON_ID_LEFT;
            evt.button_down = 1'b0;
            evt.last_of_run = !left_pend_reg && !right_pend_reg;
        end
        else if (left_pend_reg)
        begin
            evt.event_kind  = EVT_BUTTON;
            evt.button_id   = BUTTON_ID_LEFT;
            evt.button_down = left_dn_reg;
            evt.last_of_run = !right_pend_reg;
        end
        else
        begin
            evt.event_kind  = EVT_BUTTON;
            evt.button_id   = BUTTON_ID_RIGHT;
            evt.button_down = right_dn_reg;
            evt.last_of_run = 1'b1;
        end
    end

    `ASSERT_NEXT(a_run_continues, clk, rst_n, evt_xfer && !evt.last_of_run, evt_valid)
    `ASSERT_NEXT(a_left_then_right, clk, rst_n,
        evt_xfer && !evt.last_of_run && evt.event_kind == EVT_BUTTON,
        evt.event_kind == EVT_BUTTON && evt.button_id == BUTTON_ID_RIGHT)
    `ASSERT_IMPLY(a_motion_no_button, clk, rst_n,
        evt_valid && evt.event_kind == EVT_MOTION,
        evt.button_id == BUTTON_ID_LEFT && !evt.button_down)
    `ASSERT_IMPLY(a_stall_only_full, clk, rst_n, pkt_stall, in_valid_reg && evt_valid)

endmodule

`default_nettype wire
